// ----- rtl/core/ssvf_pkg.sv -----
// Package with the shared types, constants and codes of the stereo state variable filter.
package ssvf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int STATE_BITS_DEF = 20;
    localparam int COEF_BITS      = 16;
    localparam int FREQ_BITS      = COEF_BITS - 1;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = COEF_BITS;

    localparam logic [FREQ_BITS-1:0] FREQ_RESET = FREQ_BITS'(575);
    localparam logic [COEF_BITS-1:0] DAMP_RESET = COEF_BITS'(11370);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LOW   = 2'd0,
        MODE_HIGH  = 2'd1,
        MODE_BAND  = 2'd2,
        MODE_NOTCH = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE   = 2'd0,
        REG_FREQ   = 2'd1,
        REG_DAMP   = 2'd2,
        REG_UNUSED = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic mul_damp;
        logic mul_f_high;
        logic mul_f_band;
        logic upd_high;
        logic upd_band;
        logic upd_low;
    } lane_ctrl_t;

endpackage

// ----- rtl/core/stereo_state_variable_filter.sv -----
// Top level of the stereo state variable filter: sequencer, two channel lanes and output stage.
//
//   Port group  Direction  Handshake           Contents
//   in_*        input      in_valid/in_ready   action, left and right sample
//   out_*       output     out_valid/out_ready left and right filtered sample
//   cfg_*       input      cfg_wr_en           mode, freq_coef, damp_coef
//
// A filter transaction steps through the states MUL_D, HIGH, MUL_FH, BAND, MUL_FB, LOW and OUT;
// each lane steps one multiplier through three coefficient products in sequence.
// A clear transaction clears the integrators, keeps the input open and produces no result.
// Reset clears the integrators and loads the default coefficients; no clearing pass.
// The output register holds one result; a stalled output blocks only the final step.
module stereo_state_variable_filter #(
    parameter int STATE_BITS = ssvf_pkg::STATE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  ssvf_pkg::in_item_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output ssvf_pkg::out_item_t                    out_data,
    input  logic                                   cfg_wr_en,
    input  logic [ssvf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [ssvf_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL_D  = 8'b0000_0010,
        ST_HIGH   = 8'b0000_0100,
        ST_MUL_FH = 8'b0000_1000,
        ST_BAND   = 8'b0001_0000,
        ST_MUL_FB = 8'b0010_0000,
        ST_LOW    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } seq_state_t;

    seq_state_t                         state_reg;
    seq_state_t                         state_next;
    ssvf_pkg::mode_t                    mode_reg;
    logic [ssvf_pkg::FREQ_BITS-1:0]     freq_reg;
    logic [ssvf_pkg::COEF_BITS-1:0]     damp_reg;
    logic                               out_valid_reg;
    ssvf_pkg::out_item_t                out_data_reg;

    logic                               in_accept;
    logic                               slot_free;
    ssvf_pkg::lane_ctrl_t               ctrl;
    logic signed [ssvf_pkg::SAMPLE_BITS-1:0] y_left;
    logic signed [ssvf_pkg::SAMPLE_BITS-1:0] y_right;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        ctrl            = '0;
        ctrl.load       = in_accept && !in_data.action;
        ctrl.clear      = in_accept && in_data.action;
        ctrl.mul_damp   = (state_reg == ST_MUL_D);
        ctrl.upd_high   = (state_reg == ST_HIGH);
        ctrl.mul_f_high = (state_reg == ST_MUL_FH);
        ctrl.upd_band   = (state_reg == ST_BAND);
        ctrl.mul_f_band = (state_reg == ST_MUL_FB);
        ctrl.upd_low    = (state_reg == ST_LOW);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !in_data.action)
                begin
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D:  state_next = ST_HIGH;
            ST_HIGH:   state_next = ST_MUL_FH;
            ST_MUL_FH: state_next = ST_BAND;
            ST_BAND:   state_next = ST_MUL_FB;
            ST_MUL_FB: state_next = ST_LOW;
            ST_LOW:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ssvf_pkg::MODE_LOW;
            freq_reg <= ssvf_pkg::FREQ_RESET;
            damp_reg <= ssvf_pkg::DAMP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (ssvf_pkg::cfg_index_t'(cfg_index))
                ssvf_pkg::REG_MODE:
                    mode_reg <= ssvf_pkg::mode_t'(cfg_data[ssvf_pkg::MODE_BITS-1:0]);
                ssvf_pkg::REG_FREQ:
                    freq_reg <= cfg_data[ssvf_pkg::FREQ_BITS-1:0];
                ssvf_pkg::REG_DAMP:
                    damp_reg <= cfg_data[ssvf_pkg::COEF_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ssvf_lane #(
        .STATE_BITS (STATE_BITS)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (in_data.left_sample),
        .mode   (mode_reg),
        .freq   (freq_reg),
        .damp   (damp_reg),
        .y      (y_left)
    );

    ssvf_lane #(
        .STATE_BITS (STATE_BITS)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (in_data.right_sample),
        .mode   (mode_reg),
        .freq   (freq_reg),
        .damp   (damp_reg),
        .y      (y_right)
    );

    // The two lane results merge into one output transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && slot_free)
        begin
            out_data_reg.left_out  <= y_left;
            out_data_reg.right_out <= y_right;
        end
    end

endmodule

// ----- rtl/core/ssvf_lane.sv -----
// One filter channel: integrators, a shared multiplier and the output selection.
module ssvf_lane #(
    parameter int STATE_BITS = ssvf_pkg::STATE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ssvf_pkg::lane_ctrl_t                    ctrl,
    input  logic signed [ssvf_pkg::SAMPLE_BITS-1:0] sample,
    input  ssvf_pkg::mode_t                         mode,
    input  logic [ssvf_pkg::FREQ_BITS-1:0]          freq,
    input  logic [ssvf_pkg::COEF_BITS-1:0]          damp,
    output logic signed [ssvf_pkg::SAMPLE_BITS-1:0] y
);

    localparam int SB = ssvf_pkg::SAMPLE_BITS;
    localparam int CB = ssvf_pkg::COEF_BITS;
    localparam int CF = CB - 2;
    localparam int PW = STATE_BITS + CB + 1;
    localparam int WW = STATE_BITS + CB + 4;

    localparam logic signed [WW-1:0] HALF    = WW'(64'sd1 <<< (CF - 1));
    localparam logic signed [WW-1:0] ST_MAX  = WW'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] ST_MIN  = -ST_MAX - WW'(1);
    localparam logic signed [WW-1:0] SMP_MAX = WW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] SMP_MIN = -SMP_MAX - WW'(1);

    logic signed [SB-1:0]         x_reg;
    logic signed [STATE_BITS-1:0] low_reg;
    logic signed [STATE_BITS-1:0] band_reg;
    logic signed [STATE_BITS-1:0] high_reg;
    logic signed [PW-1:0]         prod_reg;

    logic signed [STATE_BITS-1:0] mul_a;
    logic signed [CB:0]           mul_b;
    logic signed [PW-1:0]         prod_next;
    logic signed [WW-1:0]         scaled;
    logic signed [WW-1:0]         high_sum;
    logic signed [WW-1:0]         band_sum;
    logic signed [WW-1:0]         low_sum;
    logic signed [WW-1:0]         notch_sum;
    logic signed [STATE_BITS-1:0] high_next;
    logic signed [STATE_BITS-1:0] band_next;
    logic signed [STATE_BITS-1:0] low_next;
    logic signed [STATE_BITS-1:0] notch_val;
    logic signed [STATE_BITS-1:0] sel_val;
    logic signed [WW-1:0]         sel_ext;

    function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] r;
        begin
            if (v > ST_MAX)
            begin
                r = ST_MAX;
            end
            else if (v < ST_MIN)
            begin
                r = ST_MIN;
            end
            else
            begin
                r = v;
            end
            return r[STATE_BITS-1:0];
        end
    endfunction

    assign mul_a     = (ctrl.mul_f_high) ? high_reg : band_reg;
    assign mul_b     = (ctrl.mul_damp) ? $signed({1'b0, damp}) : $signed({2'b00, freq});
    assign prod_next = mul_a * mul_b;

    // Round to nearest with ties upward, then drop the coefficient fraction bits.
    assign scaled    = (WW'(prod_reg) + HALF) >>> CF;
    assign high_sum  = WW'(x_reg) - scaled - WW'(low_reg);
    assign band_sum  = WW'(band_reg) + scaled;
    assign low_sum   = WW'(low_reg) + scaled;
    assign notch_sum = WW'(high_reg) + WW'(low_reg);

    assign high_next = sat_state(high_sum);
    assign band_next = sat_state(band_sum);
    assign low_next  = sat_state(low_sum);
    assign notch_val = sat_state(notch_sum);

    always_comb
    begin
        unique case (mode)
            ssvf_pkg::MODE_LOW:   sel_val = low_reg;
            ssvf_pkg::MODE_HIGH:  sel_val = high_reg;
            ssvf_pkg::MODE_BAND:  sel_val = band_reg;
            ssvf_pkg::MODE_NOTCH: sel_val = notch_val;
            default:              sel_val = notch_val;
        endcase
    end

    assign sel_ext = WW'(sel_val);

    always_comb
    begin
        if (sel_ext > SMP_MAX)
        begin
            y = SMP_MAX[SB-1:0];
        end
        else if (sel_ext < SMP_MIN)
        begin
            y = SMP_MIN[SB-1:0];
        end
        else
        begin
            y = sel_ext[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            band_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            low_reg  <= '0;
            band_reg <= '0;
        end
        else
        begin
            if (ctrl.upd_band)
            begin
                band_reg <= band_next;
            end
            if (ctrl.upd_low)
            begin
                low_reg <= low_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= sample;
        end
        if (ctrl.mul_damp || ctrl.mul_f_high || ctrl.mul_f_band)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.upd_high)
        begin
            high_reg <= high_next;
        end
    end

endmodule

// ----- rtl/core/ssvf_checker.sv -----
// Port-level checker for the stereo state variable filter and its bind statement.
module ssvf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input ssvf_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input ssvf_pkg::out_item_t out_data
);

    // A held result keeps its value until the transaction completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

    // A filter transaction closes the input after acceptance, and the input is still closed at the final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.action |=> !in_ready ##6 !in_ready)
    else $error("input reopened before the filter computation finished");

    // A clear transaction finishes at once and leaves the input open.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action |=> in_ready)
    else $error("clear transaction blocked the input");

    // A new result appears only at the end of a computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a computation");

endmodule

bind stereo_state_variable_filter ssvf_checker u_ssvf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the stereo state variable filter with a fixed-point predictor.
module testbench;

    localparam int STATE_W       = ssvf_pkg::STATE_BITS_DEF;
    localparam int SB            = ssvf_pkg::SAMPLE_BITS;
    localparam int DW            = ssvf_pkg::CFG_DATA_BITS;
    localparam int COEF_FRAC     = ssvf_pkg::COEF_BITS - 2;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int PHASES        = 8;
    localparam int PHASE_FRAMES  = 100;
    localparam logic ACT_FILTER  = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        ssvf_pkg::cfg_index_t  idx;
        logic [DW-1:0]         data;
        ssvf_pkg::in_item_t    frame;
        logic                  typed;
        ssvf_pkg::out_item_t   want;
    } stim_row_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    ssvf_pkg::in_item_t                  in_data   = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    ssvf_pkg::out_item_t                 out_data;
    logic                                cfg_wr_en = 1'b0;
    logic [ssvf_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [DW-1:0]                       cfg_data  = '0;

    ssvf_pkg::mode_t                     cur_mode;
    logic [ssvf_pkg::FREQ_BITS-1:0]      cur_freq;
    logic [ssvf_pkg::COEF_BITS-1:0]      cur_damp;
    logic signed [STATE_W-1:0]           lp_state [2];
    logic signed [STATE_W-1:0]           bp_state [2];

    ssvf_pkg::out_item_t  frames_q [$];
    stim_row_t            plan_q [$];
    int                   errors      = 0;
    int                   frames_seen = 0;
    bit                   tx_quiet    = 1'b0;

    stereo_state_variable_filter #(
        .STATE_BITS(STATE_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint clip(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Coefficient product rounded to nearest with ties going up.
    function automatic longint coef_product(input longint coef, input longint x);
        return (coef * x + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function automatic logic signed [SB-1:0] svf_lane(input int ch, input longint x);
        longint high;
        longint band;
        longint low;
        longint notch;
        longint sel;
        band = longint'(bp_state[ch]);
        low  = longint'(lp_state[ch]);
        high = clip(x - coef_product(longint'(cur_damp), band) - low, STATE_W);
        band = clip(band + coef_product(longint'(cur_freq), high), STATE_W);
        low  = clip(low + coef_product(longint'(cur_freq), band), STATE_W);
        notch = clip(high + low, STATE_W);
        bp_state[ch] = STATE_W'(band);
        lp_state[ch] = STATE_W'(low);
        case (cur_mode)
            ssvf_pkg::MODE_LOW:  sel = low;
            ssvf_pkg::MODE_HIGH: sel = high;
            ssvf_pkg::MODE_BAND: sel = band;
            default:             sel = notch;
        endcase
        return SB'(clip(sel, SB));
    endfunction

    function automatic void clear_integrators();
        for (int ch = 0; ch < 2; ch++)
        begin
            lp_state[ch] = '0;
            bp_state[ch] = '0;
        end
    endfunction

    function automatic bit predict_frame(input ssvf_pkg::in_item_t it,
                                         output ssvf_pkg::out_item_t res);
        res = '0;
        if (it.action == ACT_CLEAR)
        begin
            clear_integrators();
            return 1'b0;
        end
        res.left_out  = svf_lane(0, longint'(it.left_sample));
        res.right_out = svf_lane(1, longint'(it.right_sample));
        return 1'b1;
    endfunction

    function automatic void apply_reg(input ssvf_pkg::cfg_index_t idx,
                                      input logic [DW-1:0] data);
        case (idx)
            ssvf_pkg::REG_MODE:
                cur_mode = ssvf_pkg::mode_t'(data[ssvf_pkg::MODE_BITS-1:0]);
            ssvf_pkg::REG_FREQ: cur_freq = data[ssvf_pkg::FREQ_BITS-1:0];
            ssvf_pkg::REG_DAMP: cur_damp = data[ssvf_pkg::COEF_BITS-1:0];
            default:  ;
        endcase
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SB'(int'($urandom_range(0, 511)) - 256);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic ssvf_pkg::in_item_t rand_frame();
        ssvf_pkg::in_item_t it;
        it.action       = ($urandom_range(0, 24) == 0) ? ACT_CLEAR : ACT_FILTER;
        it.left_sample  = rand_sample();
        it.right_sample = rand_sample();
        return it;
    endfunction

    function automatic logic [DW-1:0] rand_freq();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, 15'($urandom)};
            default: return DW'($urandom_range(1, 8000));
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_damp();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DW'(32768);
            2:       return '1;
            default: return DW'($urandom_range(2000, 32767));
        endcase
    endfunction

    function automatic void plan_frame(input logic act, input int l, input int r,
                                       input bit typed, input int wl, input int wr);
        stim_row_t row;
        row                    = '0;
        row.kind               = ROW_FRAME;
        row.frame.action       = act;
        row.frame.left_sample  = SB'(l);
        row.frame.right_sample = SB'(r);
        row.typed              = typed;
        row.want.left_out      = SB'(wl);
        row.want.right_out     = SB'(wr);
        plan_q.push_back(row);
    endfunction

    function automatic void plan_reg(input ssvf_pkg::cfg_index_t idx, input int data);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_REG;
        row.idx  = idx;
        row.data = DW'(data);
        plan_q.push_back(row);
    endfunction

    task automatic send_frame(input ssvf_pkg::in_item_t it, input bit typed,
                              input ssvf_pkg::out_item_t want);
        int                  gap;
        ssvf_pkg::out_item_t res;
        gap = tx_quiet ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        if (predict_frame(it, res))
            frames_q.push_back(typed ? want : res);
    endtask

    task automatic settle(input int max_cycles);
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (frames_q.size() != 0 && n < max_cycles)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ssvf_pkg::cfg_index_t idx, input logic [DW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        apply_reg(idx, data);
        @(posedge clk);
    endtask

    initial
    begin : result_sink
        int                  stall_left;
        int                  quiet_left;
        bit                  long_done;
        ssvf_pkg::out_item_t want;
        stall_left = 0;
        quiet_left = 0;
        long_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                frames_seen++;
                if (frames_q.size() == 0)
                begin
                    $display("%0t: unexpected result, left %0d right %0d",
                             $time, out_data.left_out, out_data.right_out);
                    errors++;
                end
                else
                begin
                    want = frames_q.pop_front();
                    if (out_data.left_out !== want.left_out)
                    begin
                        $display("%0t: left_out expected %0d, got %0d",
                                 $time, want.left_out, out_data.left_out);
                        errors++;
                    end
                    if (out_data.right_out !== want.right_out)
                    begin
                        $display("%0t: right_out expected %0d, got %0d",
                                 $time, want.right_out, out_data.right_out);
                        errors++;
                    end
                end
            end
            if (!long_done && frames_seen >= 100)
            begin
                long_done  = 1'b1;
                stall_left = 400;
            end
            else if (stall_left == 0)
            begin
                if (quiet_left > 0)
                    quiet_left--;
                else if ($urandom_range(0, 59) == 0)
                    quiet_left = $urandom_range(50, 150);
                else
                    stall_left = gap_len();
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        cur_mode = ssvf_pkg::MODE_LOW;
        cur_freq = ssvf_pkg::FREQ_RESET;
        cur_damp = ssvf_pkg::DAMP_RESET;
        clear_integrators();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: silence in gives silence out, extremes go through the predictor.
        plan_frame(ACT_FILTER, 0, 0, 1'b1, 0, 0);
        plan_frame(ACT_FILTER, 32767, -32768, 1'b0, 0, 0);
        plan_frame(ACT_FILTER, -32768, 32767, 1'b0, 0, 0);
        plan_frame(ACT_CLEAR, 0, 0, 1'b0, 0, 0);
        // With zero coefficients the integrators stay at zero, so high and notch pass the input.
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_HIGH);
        plan_reg(ssvf_pkg::REG_FREQ, 0);
        plan_reg(ssvf_pkg::REG_DAMP, 0);
        plan_frame(ACT_FILTER, 32767, -32768, 1'b1, 32767, -32768);
        plan_frame(ACT_FILTER, -1, 1, 1'b1, -1, 1);
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_BAND);
        plan_frame(ACT_FILTER, 12345, -12345, 1'b1, 0, 0);
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_NOTCH);
        plan_frame(ACT_FILTER, -32768, 32767, 1'b1, -32768, 32767);
        // A write to the unused index must leave every register alone.
        plan_reg(ssvf_pkg::REG_UNUSED, 65535);
        plan_frame(ACT_FILTER, 100, -100, 1'b1, 100, -100);
        plan_frame(ACT_CLEAR, 0, 0, 1'b0, 0, 0);
        // Largest coefficients make the loop unstable, driving state and output into saturation.
        plan_reg(ssvf_pkg::REG_FREQ, 65535);
        plan_reg(ssvf_pkg::REG_DAMP, 32768);
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_LOW);
        for (int k = 0; k < 3; k++)
            plan_frame(ACT_FILTER, 32767, -32768, 1'b0, 0, 0);
        for (int k = 0; k < 3; k++)
            plan_frame(ACT_FILTER, -32768, 32767, 1'b0, 0, 0);
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_HIGH);
        plan_frame(ACT_FILTER, 32767, 32767, 1'b0, 0, 0);
        plan_frame(ACT_FILTER, -32768, -32768, 1'b0, 0, 0);
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_BAND);
        plan_frame(ACT_FILTER, 32767, -32768, 1'b0, 0, 0);
        plan_frame(ACT_FILTER, 0, 0, 1'b0, 0, 0);
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_NOTCH);
        plan_frame(ACT_FILTER, -32768, 32767, 1'b0, 0, 0);
        plan_frame(ACT_FILTER, 1, -1, 1'b0, 0, 0);
        plan_frame(ACT_CLEAR, 0, 0, 1'b0, 0, 0);
        plan_reg(ssvf_pkg::REG_FREQ, 575);
        plan_reg(ssvf_pkg::REG_DAMP, 11370);
        plan_reg(ssvf_pkg::REG_MODE, ssvf_pkg::MODE_LOW);
        plan_frame(ACT_FILTER, 16384, -16384, 1'b0, 0, 0);
        plan_frame(ACT_FILTER, 16384, -16384, 1'b0, 0, 0);

        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.kind == ROW_REG)
            begin
                settle(DRAIN_LIMIT);
                write_reg(row.idx, row.data);
            end
            else
                send_frame(row.frame, row.typed, row.want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle(DRAIN_LIMIT);
            write_reg(ssvf_pkg::REG_MODE, DW'($urandom_range(0, 3)));
            write_reg(ssvf_pkg::REG_FREQ, rand_freq());
            write_reg(ssvf_pkg::REG_DAMP, rand_damp());
            if ($urandom_range(0, 3) == 0)
                write_reg(ssvf_pkg::REG_UNUSED, DW'($urandom));
            tx_quiet = (ph % 3 == 2);
            for (int k = 0; k < PHASE_FRAMES; k++)
                send_frame(rand_frame(), 1'b0, '0);
        end

        settle(DRAIN_LIMIT);
        if (frames_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, frames_q.size());
            errors++;
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ssvf_pkg.sv
rtl/core/ssvf_lane.sv
rtl/core/stereo_state_variable_filter.sv
rtl/core/ssvf_checker.sv
sim/testbench.sv
